/* design/lcdw_pkg.sv */
`default_nettype none

package lcdw_pkg;

    localparam int QUEUE_DEPTH_DEF = 64;
    localparam int LEVEL_W         = 7;
    localparam int CFG_INDEX_W     = 3;
    localparam int OPQ_DEPTH       = 2;

    localparam logic [1:0] FUNC_TICK     = 2'd0;
    localparam logic [1:0] FUNC_PUSH_RAW = 2'd1;
    localparam logic [1:0] FUNC_PUSH_POS = 2'd2;

    localparam logic [7:0] CURSOR_BASE_ROW0 = 8'h80;
    localparam logic [7:0] CURSOR_BASE_ROW1 = 8'hC0;
    localparam logic [7:0] RECORD_END       = 8'h00;

    localparam logic [CFG_INDEX_W-1:0] CFG_CMD_NIBBLE_TICKS  = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_POS_NIBBLE_TICKS  = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_CHAR_NIBBLE_TICKS = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_SETTLE_TICKS      = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_CHAR_SETTLE_TICKS = 3'd4;

    localparam logic [7:0] CMD_NIBBLE_TICKS_RST  = 8'd2;
    localparam logic [7:0] POS_NIBBLE_TICKS_RST  = 8'd1;
    localparam logic [7:0] CHAR_NIBBLE_TICKS_RST = 8'd1;
    localparam logic [7:0] SETTLE_TICKS_RST      = 8'd4;
    localparam logic [7:0] CHAR_SETTLE_TICKS_RST = 8'd1;

    typedef enum logic [1:0] {
        OP_TICK,
        OP_PUSH,
        OP_NOP
    } t_op_kind;

    typedef struct packed {
        t_op_kind   kind;
        logic [7:0] data;
    } t_op;

    typedef struct packed {
        logic                   valid;
        logic [CFG_INDEX_W-1:0] index;
        logic [7:0]             data;
    } t_cfg_wr;

    typedef enum logic [3:0] {
        PH_IDLE,
        PH_CMD_HI,
        PH_CMD_LO,
        PH_CMD_LATCH,
        PH_POS_HI,
        PH_POS_LO,
        PH_POS_LATCH,
        PH_CHR_HI,
        PH_CHR_LO,
        PH_CHR_LATCH
    } t_phase;

endpackage

`default_nettype wire

/* design/char_lcd_queued_nibble_writer.sv */
`default_nettype none

// Character LCD writer for the 4-bit bus of a standard character display controller. Items
// either push a byte (raw, or a cursor byte built from row and column) into a byte ring queue,
// or tick the sequencer, which sends each queued record (command, cursor byte, characters up to
// a zero byte) as high nibble, low nibble and strobe release, with the configured hold and
// settle waits counted in ticks. One item is accepted every clock cycle for as long as the
// result side keeps up; each result passes through the two-entry item queue of the front end
// and then the output registers of the back end, where a single queue write or a single
// sequencer step with one registered read of the byte RAM is done per cycle. Every item gives
// exactly one result, carrying the pin levels, the busy flag, the drop flag and the queue level
// after that item. The configuration port is always ready and is to be written only while idle.
module char_lcd_queued_nibble_writer #(
    parameter int QUEUE_DEPTH = lcdw_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_rst_n,
    input  wire logic                                   i_in_valid,
    output logic                                        o_in_stall,
    input  wire logic [1:0]                             i_func,
    input  wire logic [7:0]                             i_push_byte,
    input  wire logic                                   i_row,
    input  wire logic [5:0]                             i_column,
    output logic                                        o_out_valid,
    input  wire logic                                   i_out_stall,
    output logic                                        o_lcd_rs,
    output logic                                        o_lcd_e,
    output logic [3:0]                                  o_lcd_nibble,
    output logic                                        o_busy_res,
    output logic                                        o_dropped,
    output logic [lcdw_pkg::LEVEL_W-1:0]                o_queue_level,
    input  wire logic                                   i_cfg_valid,
    output logic                                        o_cfg_ready,
    input  wire logic [lcdw_pkg::CFG_INDEX_W-1:0]       i_cfg_index,
    input  wire logic [7:0]                             i_cfg_data
);

    import lcdw_pkg::*;

    t_cfg_wr cfg_wr;
    t_op     op;
    logic    op_valid;
    logic    op_take;

    assign o_cfg_ready  = 1'b1;
    assign cfg_wr.valid = i_cfg_valid;
    assign cfg_wr.index = i_cfg_index;
    assign cfg_wr.data  = i_cfg_data;

    lcdw_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_func      (i_func),
        .i_push_byte (i_push_byte),
        .i_row       (i_row),
        .i_column    (i_column),
        .o_op_valid  (op_valid),
        .o_op        (op),
        .i_op_take   (op_take)
    );

    lcdw_back #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (cfg_wr),
        .i_op_valid    (op_valid),
        .i_op          (op),
        .o_op_take     (op_take),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_lcd_rs      (o_lcd_rs),
        .o_lcd_e       (o_lcd_e),
        .o_lcd_nibble  (o_lcd_nibble),
        .o_busy_res    (o_busy_res),
        .o_dropped     (o_dropped),
        .o_queue_level (o_queue_level)
    );

    // A dropped push can only have met a full queue.
    a_drop_full : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_dropped) |-> (o_queue_level == LEVEL_W'(QUEUE_DEPTH)))
        else $error("dropped push reported with a queue that is not full");

    // The strobe is only ever raised by a sequencer that is working through a record.
    a_strobe_busy : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_lcd_e) |-> o_busy_res)
        else $error("strobe raised while the sequencer is idle");

    // A record ends only after the strobe of its last character has been released.
    a_idle_strobe : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_busy_res |-> !o_lcd_e)
        else $error("strobe left high with the sequencer idle");

    // An item waiting at the front end is taken once the result side is free.
    a_progress : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (op_valid && !i_out_stall) |-> op_take)
        else $error("queued item not taken with the result side free");

endmodule

`default_nettype wire

/* design/lcdw_ram.sv */
`default_nettype none

module lcdw_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

/* design/lcdw_front.sv */
`default_nettype none

module lcdw_front (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    output logic               o_in_stall,
    input  wire logic [1:0]    i_func,
    input  wire logic [7:0]    i_push_byte,
    input  wire logic          i_row,
    input  wire logic [5:0]    i_column,
    output logic               o_op_valid,
    output lcdw_pkg::t_op      o_op,
    input  wire logic          i_op_take
);

    import lcdw_pkg::*;

    t_op        slot_in;
    t_op        r_slot [OPQ_DEPTH];
    logic       r_wptr;
    logic       r_rptr;
    logic [1:0] r_count;
    logic [1:0] n_count;
    logic       accept;

    always_comb begin
        slot_in.data = i_push_byte;
        unique case (i_func)
            FUNC_TICK: begin
                slot_in.kind = OP_TICK;
            end
            FUNC_PUSH_RAW: begin
                slot_in.kind = OP_PUSH;
            end
            FUNC_PUSH_POS: begin
                slot_in.kind = OP_PUSH;
                slot_in.data = (i_row ? CURSOR_BASE_ROW1 : CURSOR_BASE_ROW0) | {2'b00, i_column};
            end
            default: begin
                slot_in.kind = OP_NOP;
            end
        endcase
    end

    assign o_in_stall = (r_count == 2'(OPQ_DEPTH));
    assign accept     = i_in_valid && !o_in_stall;
    assign o_op_valid = (r_count != 2'd0);
    assign o_op       = r_slot[r_rptr];

    always_comb begin
        n_count = r_count;
        if (accept && !i_op_take) begin
            n_count = r_count + 2'd1;
        end else if (!accept && i_op_take) begin
            n_count = r_count - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_slot[r_wptr] <= slot_in;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= 1'b0;
            r_rptr  <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (accept) begin
                r_wptr <= ~r_wptr;
            end
            if (i_op_take) begin
                r_rptr <= ~r_rptr;
            end
            r_count <= n_count;
        end
    end

endmodule

`default_nettype wire

/* design/lcdw_back.sv */
`default_nettype none

module lcdw_back #(
    parameter int QUEUE_DEPTH = lcdw_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire lcdw_pkg::t_cfg_wr                  i_cfg,
    input  wire logic                               i_op_valid,
    input  wire lcdw_pkg::t_op                      i_op,
    output logic                                    o_op_take,
    output logic                                    o_out_valid,
    input  wire logic                               i_out_stall,
    output logic                                    o_lcd_rs,
    output logic                                    o_lcd_e,
    output logic [3:0]                              o_lcd_nibble,
    output logic                                    o_busy_res,
    output logic                                    o_dropped,
    output logic [lcdw_pkg::LEVEL_W-1:0]            o_queue_level
);

    import lcdw_pkg::*;

    localparam int AW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam int LW = (CW > LEVEL_W) ? CW : LEVEL_W;

    logic [7:0]    r_cmd_ticks;
    logic [7:0]    r_pos_ticks;
    logic [7:0]    r_chr_ticks;
    logic [7:0]    r_settle_ticks;
    logic [7:0]    r_chr_settle_ticks;

    logic [AW-1:0] r_ridx;
    logic [AW-1:0] n_ridx;
    logic [AW-1:0] r_widx;
    logic [AW-1:0] n_widx;
    logic [CW-1:0] r_fill;
    logic [CW-1:0] n_fill;
    logic [LW-1:0] fill_ext;

    t_phase        r_phase;
    t_phase        n_phase;
    logic [7:0]    r_wait;
    logic [7:0]    n_wait;
    logic          r_rs;
    logic          n_rs;
    logic          r_e;
    logic          n_e;
    logic [3:0]    r_nib;
    logic [3:0]    n_nib;
    logic          r_out_valid;
    logic          n_out_valid;
    logic          r_dropped;
    logic          n_dropped;

    logic          r_byp_valid;
    logic [7:0]    r_byp_data;
    logic [7:0]    ram_rdata;
    logic [7:0]    head;

    logic          fire;
    logic          is_tick;
    logic          is_push;
    logic          full;
    logic          do_write;
    logic          do_step;
    logic          pop;
    logic [7:0]    hold_ticks;

    assign fire     = i_op_valid && (!r_out_valid || !i_out_stall);
    assign is_tick  = fire && (i_op.kind == OP_TICK);
    assign is_push  = fire && (i_op.kind == OP_PUSH);
    assign full     = (r_fill == CW'(QUEUE_DEPTH));
    assign do_write = is_push && !full;
    assign do_step  = is_tick && (r_wait == 8'd0) && (r_fill != '0);
    assign head     = r_byp_valid ? r_byp_data : ram_rdata;

    assign o_op_take = fire;

    lcdw_ram #(
        .WIDTH (8),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_we    (do_write),
        .i_waddr (r_widx),
        .i_wdata (i_op.data),
        .i_raddr (n_ridx),
        .o_rdata (ram_rdata)
    );

    // The sequencer holds its phase while the queue is empty.
    always_comb begin
        n_phase = r_phase;
        if (do_step) begin
            unique case (r_phase)
                PH_IDLE:      n_phase = PH_CMD_HI;
                PH_CMD_HI:    n_phase = PH_CMD_LO;
                PH_CMD_LO:    n_phase = PH_CMD_LATCH;
                PH_CMD_LATCH: n_phase = PH_POS_HI;
                PH_POS_HI:    n_phase = PH_POS_LO;
                PH_POS_LO:    n_phase = PH_POS_LATCH;
                PH_POS_LATCH: n_phase = PH_CHR_HI;
                PH_CHR_HI:    n_phase = (head == RECORD_END) ? PH_IDLE : PH_CHR_LO;
                PH_CHR_LO:    n_phase = PH_CHR_LATCH;
                PH_CHR_LATCH: n_phase = PH_CHR_HI;
                default:      n_phase = PH_IDLE;
            endcase
        end
    end

    always_comb begin
        unique case (r_phase)
            PH_CMD_HI, PH_CMD_LO: hold_ticks = r_cmd_ticks;
            PH_POS_HI, PH_POS_LO: hold_ticks = r_pos_ticks;
            default:              hold_ticks = r_chr_ticks;
        endcase
    end

    always_comb begin
        n_rs   = r_rs;
        n_e    = r_e;
        n_nib  = r_nib;
        n_wait = r_wait;
        pop    = 1'b0;
        if (is_tick && (r_wait != 8'd0)) begin
            n_wait = r_wait - 8'd1;
        end
        if (do_step) begin
            unique case (r_phase)
                PH_CMD_HI, PH_POS_HI: begin
                    n_rs   = 1'b0;
                    n_nib  = head[7:4];
                    n_e    = 1'b1;
                    n_wait = hold_ticks;
                end
                PH_CHR_HI: begin
                    if (head == RECORD_END) begin
                        pop = 1'b1;
                    end else begin
                        n_rs   = 1'b1;
                        n_nib  = head[7:4];
                        n_e    = 1'b1;
                        n_wait = hold_ticks;
                    end
                end
                PH_CMD_LO, PH_POS_LO, PH_CHR_LO: begin
                    n_nib  = head[3:0];
                    n_e    = 1'b1;
                    n_wait = hold_ticks;
                end
                PH_CMD_LATCH, PH_POS_LATCH: begin
                    n_e    = 1'b0;
                    pop    = 1'b1;
                    n_wait = r_settle_ticks;
                end
                PH_CHR_LATCH: begin
                    n_e    = 1'b0;
                    pop    = 1'b1;
                    n_wait = r_chr_settle_ticks;
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        n_ridx = r_ridx;
        if (pop) begin
            n_ridx = (r_ridx == AW'(QUEUE_DEPTH - 1)) ? '0 : r_ridx + AW'(1);
        end
        n_widx = r_widx;
        if (do_write) begin
            n_widx = (r_widx == AW'(QUEUE_DEPTH - 1)) ? '0 : r_widx + AW'(1);
        end
        n_fill = r_fill;
        if (do_write) begin
            n_fill = r_fill + CW'(1);
        end else if (pop) begin
            n_fill = r_fill - CW'(1);
        end
        n_dropped   = fire ? (is_push && full) : r_dropped;
        n_out_valid = fire ? 1'b1 : (i_out_stall ? r_out_valid : 1'b0);
    end

    // A write to the address being read this cycle is forwarded past the RAM.
    always_ff @(posedge i_clk) begin
        r_byp_data <= i_op.data;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cmd_ticks        <= CMD_NIBBLE_TICKS_RST;
            r_pos_ticks        <= POS_NIBBLE_TICKS_RST;
            r_chr_ticks        <= CHAR_NIBBLE_TICKS_RST;
            r_settle_ticks     <= SETTLE_TICKS_RST;
            r_chr_settle_ticks <= CHAR_SETTLE_TICKS_RST;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                CFG_CMD_NIBBLE_TICKS:  r_cmd_ticks        <= i_cfg.data;
                CFG_POS_NIBBLE_TICKS:  r_pos_ticks        <= i_cfg.data;
                CFG_CHAR_NIBBLE_TICKS: r_chr_ticks        <= i_cfg.data;
                CFG_SETTLE_TICKS:      r_settle_ticks     <= i_cfg.data;
                CFG_CHAR_SETTLE_TICKS: r_chr_settle_ticks <= i_cfg.data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ridx      <= '0;
            r_widx      <= '0;
            r_fill      <= '0;
            r_phase     <= PH_IDLE;
            r_wait      <= 8'd0;
            r_rs        <= 1'b0;
            r_e         <= 1'b0;
            r_nib       <= 4'd0;
            r_out_valid <= 1'b0;
            r_dropped   <= 1'b0;
            r_byp_valid <= 1'b0;
        end else begin
            r_ridx      <= n_ridx;
            r_widx      <= n_widx;
            r_fill      <= n_fill;
            r_phase     <= n_phase;
            r_wait      <= n_wait;
            r_rs        <= n_rs;
            r_e         <= n_e;
            r_nib       <= n_nib;
            r_out_valid <= n_out_valid;
            r_dropped   <= n_dropped;
            r_byp_valid <= do_write && (r_widx == n_ridx);
        end
    end

    assign fill_ext      = LW'(r_fill);
    assign o_out_valid   = r_out_valid;
    assign o_lcd_rs      = r_rs;
    assign o_lcd_e       = r_e;
    assign o_lcd_nibble  = r_nib;
    assign o_busy_res    = (r_phase != PH_IDLE);
    assign o_dropped     = r_dropped;
    assign o_queue_level = fill_ext[LEVEL_W-1:0];

endmodule

`default_nettype wire
